// File: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and fixed-point constants of the quaternion to Euler angle core.
// ----------------------------------------------------------------------------
package qte_pkg;

   // Q16 radians and unit conversion
   localparam logic signed [19:0] PI_Q16       = 20'sd205887;
   localparam logic signed [19:0] PIBY2_Q16    = 20'sd102944;
   localparam logic        [31:0] PIBY2_Q30    = 32'd1686629713;
   localparam logic        [12:0] CDEG_PER_RAD = 13'd5730;
   localparam logic signed [33:0] ONE_Q28      = 34'sd268435456;

   localparam int DIV_STEPS    = 16;
   localparam int SQRT_STEPS   = 31;
   localparam int HORNER_STEPS = 7;

   typedef logic signed [31:0] coef_type;

   // arcsine polynomial, Q30, constant term first
   localparam coef_type ASIN_COEF [0:7] = '{
      32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874249,
      32'sd33169905, -32'sd18348235, 32'sd7161955, -32'sd1355590
   };

   // rounded Q14 atan2 operands
   typedef struct packed {
      logic               valid;
      logic signed [19:0] y;
      logic signed [19:0] x;
   } atan_opnd_type;

   // clamped arcsine argument magnitude in Q30
   typedef struct packed {
      logic        valid;
      logic        neg;
      logic [30:0] x;
   } asin_opnd_type;

endpackage

// File: hdl/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Four register stages: normalize components to Q14, form the products, sum
// them into the atan2 and arcsine arguments, round and clamp.
// ----------------------------------------------------------------------------
module qte_front #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [QUAT_WIDTH-1:0]  quat_w,
   input  logic signed [QUAT_WIDTH-1:0]  quat_x,
   input  logic signed [QUAT_WIDTH-1:0]  quat_y,
   input  logic signed [QUAT_WIDTH-1:0]  quat_z,
   output qte_pkg::atan_opnd_type        roll_opnd,
   output qte_pkg::atan_opnd_type        yaw_opnd,
   output qte_pkg::asin_opnd_type        asin_opnd
);
   import qte_pkg::*;

   logic signed [QUAT_WIDTH-1:0] raw [4];
   logic signed [15:0]           q_in [4];
   logic signed [15:0]           q_ff [4];
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic signed [31:0] p01_ff, p23_ff, p11_ff, p22_ff, p03_ff;
   logic signed [31:0] p12_ff, p33_ff, p02_ff, p31_ff;
   logic signed [33:0] ry_ff, rx_ff, yy_ff, yx_ff, s_ff;
   logic signed [19:0] roll_y_ff, roll_x_ff, yaw_y_ff, yaw_x_ff;
   logic [33:0]        s_mag_in;
   logic [30:0]        asin_x_in;
   logic [30:0]        asin_x_ff;
   logic               asin_neg_ff;

   // round a Q28 value to Q14, half away from zero
   function automatic logic signed [19:0] round_q14(input logic signed [33:0] v);
      logic [33:0]        mag;
      logic [33:0]        sum;
      logic signed [19:0] r;
      mag = v[33] ? 34'(-v) : 34'(v);
      sum = mag + 34'd8192;
      r   = $signed(20'(sum >> 14));
      return v[33] ? -r : r;
   endfunction

   assign raw[0] = quat_w;
   assign raw[1] = quat_x;
   assign raw[2] = quat_y;
   assign raw[3] = quat_z;

   for (genvar i = 0; i < 4; i++) begin : g_norm
      if (QUAT_WIDTH > 16) begin : g_trunc
         localparam int SH = QUAT_WIDTH - 16;
         logic signed [QUAT_WIDTH:0] biased;
         logic signed [QUAT_WIDTH:0] shifted;
         // bias negatives so the shift truncates toward zero
         assign biased  = {raw[i][QUAT_WIDTH-1], raw[i]} +
                          (raw[i][QUAT_WIDTH-1] ? (QUAT_WIDTH+1)'((1 << SH) - 1)
                                                : (QUAT_WIDTH+1)'(0));
         assign shifted = biased >>> SH;
         assign q_in[i] = shifted[15:0];
      end else if (QUAT_WIDTH == 16) begin : g_same
         assign q_in[i] = raw[i];
      end else begin : g_widen
         assign q_in[i] = {raw[i], {(16-QUAT_WIDTH){1'b0}}};
      end
   end

   always_comb begin
      s_mag_in = s_ff[33] ? 34'(-s_ff) : 34'(s_ff);
      if (s_mag_in > 34'(ONE_Q28)) begin
         s_mag_in = 34'(ONE_Q28);
      end
      asin_x_in = {s_mag_in[28:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         q_ff[i] <= q_in[i];
      end
      p01_ff <= q_ff[0] * q_ff[1];
      p23_ff <= q_ff[2] * q_ff[3];
      p11_ff <= q_ff[1] * q_ff[1];
      p22_ff <= q_ff[2] * q_ff[2];
      p03_ff <= q_ff[0] * q_ff[3];
      p12_ff <= q_ff[1] * q_ff[2];
      p33_ff <= q_ff[3] * q_ff[3];
      p02_ff <= q_ff[0] * q_ff[2];
      p31_ff <= q_ff[3] * q_ff[1];
      ry_ff  <= (34'(p01_ff) + 34'(p23_ff)) <<< 1;
      rx_ff  <= ONE_Q28 - ((34'(p11_ff) + 34'(p22_ff)) <<< 1);
      yy_ff  <= (34'(p03_ff) + 34'(p12_ff)) <<< 1;
      yx_ff  <= ONE_Q28 - ((34'(p22_ff) + 34'(p33_ff)) <<< 1);
      s_ff   <= (34'(p02_ff) - 34'(p31_ff)) <<< 1;
      roll_y_ff   <= round_q14(ry_ff);
      roll_x_ff   <= round_q14(rx_ff);
      yaw_y_ff    <= round_q14(yy_ff);
      yaw_x_ff    <= round_q14(yx_ff);
      asin_x_ff   <= asin_x_in;
      asin_neg_ff <= s_ff[33];
   end

   assign roll_opnd = '{valid: f4_valid_ff, y: roll_y_ff, x: roll_x_ff};
   assign yaw_opnd  = '{valid: f4_valid_ff, y: yaw_y_ff, x: yaw_x_ff};
   assign asin_opnd = '{valid: f4_valid_ff, neg: asin_neg_ff, x: asin_x_ff};

endmodule

// File: hdl/qte_atan.sv
// ----------------------------------------------------------------------------
// qte_atan
// Pipelined rational atan2 with quadrant fix-up and conversion to centidegrees.
// Twenty register stages, sixteen of them a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module qte_atan (
   input  logic                   clock,
   input  logic                   reset,
   input  qte_pkg::atan_opnd_type opnd,
   output logic                   out_valid,
   output logic signed [15:0]     cdeg
);
   import qte_pkg::*;

   typedef struct packed {
      logic xzero;
      logic xneg;
      logic yneg;
      logic ypos;
      logic y_below;
   } side_type;

   logic [18:0] ax_in, ay_in;
   logic [37:0] axx_ff, ayy_ff, axy_ff;
   side_type    side1_ff;
   logic        vld1_ff;

   logic [41:0] num_in, den_in, half_in;

   logic [41:0]           rem_ff  [DIV_STEPS+1];
   logic [41:0]           den_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]  low_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]  q_ff    [DIV_STEPS+1];
   side_type              side_ff [DIV_STEPS+1];
   logic                  vld_ff  [DIV_STEPS+1];

   side_type           sd;
   logic signed [19:0] sq, a_in;
   logic [18:0]        amag_in;
   logic [18:0]        amag_ff;
   logic               aneg_ff;
   logic               avld_ff;

   logic [31:0]        scaled_in;
   logic signed [15:0] cdeg_in;
   logic signed [15:0] cdeg_ff;
   logic               out_vld_ff;

   assign ax_in = opnd.x[19] ? 19'(-opnd.x) : 19'(opnd.x);
   assign ay_in = opnd.y[19] ? 19'(-opnd.y) : 19'(opnd.y);

   always_ff @(posedge clock) begin
      axx_ff           <= 38'(ax_in) * 38'(ax_in);
      ayy_ff           <= 38'(ay_in) * 38'(ay_in);
      axy_ff           <= 38'(ax_in) * 38'(ay_in);
      side1_ff.xzero   <= (opnd.x == 20'sd0);
      side1_ff.xneg    <= opnd.x[19];
      side1_ff.yneg    <= opnd.y[19];
      side1_ff.ypos    <= !opnd.y[19] && (opnd.y != 20'sd0);
      side1_ff.y_below <= ay_in < ax_in;
   end

   // numerator and denominator of the octant quotient
   assign num_in  = 42'(axy_ff) * 42'd25;
   assign den_in  = side1_ff.y_below ? 42'(axx_ff) * 42'd25 + 42'(ayy_ff) * 42'd7
                                     : 42'(ayy_ff) * 42'd25 + 42'(axx_ff) * 42'd7;
   assign half_in = den_in >> 1;

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num_in + (half_in >> DIV_STEPS);
      low_ff[0]  <= half_in[DIV_STEPS-1:0];
      den_ff[0]  <= den_in;
      q_ff[0]    <= '0;
      side_ff[0] <= side1_ff;
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      logic [42:0] trial;
      logic [42:0] diff;
      assign trial = {rem_ff[s-1], low_ff[s-1][DIV_STEPS-s]};
      assign diff  = trial - {1'b0, den_ff[s-1]};
      always_ff @(posedge clock) begin
         if (trial >= {1'b0, den_ff[s-1]}) begin
            rem_ff[s] <= diff[41:0];
            q_ff[s]   <= {q_ff[s-1][DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff[s] <= trial[41:0];
            q_ff[s]   <= {q_ff[s-1][DIV_STEPS-2:0], 1'b0};
         end
         den_ff[s]  <= den_ff[s-1];
         low_ff[s]  <= low_ff[s-1];
         side_ff[s] <= side_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_comb begin
      sd = side_ff[DIV_STEPS];
      sq = (sd.xneg ^ sd.yneg) ? -$signed({4'b0, q_ff[DIV_STEPS]})
                               : $signed({4'b0, q_ff[DIV_STEPS]});
      if (sd.xzero) begin
         a_in = sd.ypos ? PIBY2_Q16 : (sd.yneg ? -PIBY2_Q16 : 20'sd0);
      end else if (sd.y_below) begin
         a_in = sq + (sd.xneg ? (sd.yneg ? -PI_Q16 : PI_Q16) : 20'sd0);
      end else begin
         a_in = PIBY2_Q16 - sq - (sd.yneg ? PI_Q16 : 20'sd0);
      end
      amag_in = a_in[19] ? 19'(-a_in) : 19'(a_in);
   end

   always_ff @(posedge clock) begin
      amag_ff <= amag_in;
      aneg_ff <= a_in[19];
   end

   assign scaled_in = 32'(amag_ff) * 32'(CDEG_PER_RAD) + 32'd32768;
   assign cdeg_in   = aneg_ff ? -$signed(scaled_in[31:16]) : $signed(scaled_in[31:16]);

   always_ff @(posedge clock) begin
      cdeg_ff <= cdeg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld_ff[0]  <= 1'b0;
         avld_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld1_ff    <= opnd.valid;
         vld_ff[0]  <= vld1_ff;
         avld_ff    <= vld_ff[DIV_STEPS];
         out_vld_ff <= avld_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign cdeg      = cdeg_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && !side_ff[DIV_STEPS].xzero |->
         rem_ff[DIV_STEPS] < den_ff[DIV_STEPS])
      else $error("divider remainder not below divisor");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (cdeg_ff <= 16'sd18010) && (cdeg_ff >= -16'sd18010))
      else $error("atan2 angle out of range");

endmodule

// File: hdl/qte_asin.sv
// ----------------------------------------------------------------------------
// qte_asin
// Pipelined arcsine for pitch: a one-bit-per-stage square root runs beside the
// Horner polynomial, then product, offset from pi/2 and centidegree scaling.
// Thirty-four register stages.
// ----------------------------------------------------------------------------
module qte_asin (
   input  logic                   clock,
   input  logic                   reset,
   input  qte_pkg::asin_opnd_type opnd,
   output logic                   out_valid,
   output logic signed [14:0]     pitch_cdeg
);
   import qte_pkg::*;

   localparam int LAST = SQRT_STEPS - 1;

   logic [61:0]        vi    [SQRT_STEPS];
   logic [61:0]        ri    [SQRT_STEPS];
   logic signed [63:0] hi    [SQRT_STEPS];
   logic [30:0]        xi    [SQRT_STEPS];
   logic               ni    [SQRT_STEPS];
   logic               vldi  [SQRT_STEPS];

   logic [61:0]        v_ff   [SQRT_STEPS];
   logic [61:0]        r_ff   [SQRT_STEPS];
   logic signed [63:0] h_ff   [SQRT_STEPS];
   logic [30:0]        x_ff   [SQRT_STEPS];
   logic               neg_ff [SQRT_STEPS];
   logic               vld_ff [SQRT_STEPS];

   logic signed [63:0] tprod_in, tprod_ff;
   logic               tneg_ff, tvld_ff;
   logic signed [63:0] t_full;
   logic signed [33:0] as_in;
   logic [31:0]        amag_in, amag_ff;
   logic               aneg_ff, avld_ff;
   logic [45:0]        scaled_in;
   logic signed [14:0] pitch_in, pitch_ff;
   logic               out_vld_ff;

   // divide by 2^30, truncating toward zero
   function automatic logic signed [63:0] trunc_q30(input logic signed [63:0] v);
      logic signed [63:0] b;
      b = v + (v[63] ? 64'sd1073741823 : 64'sd0);
      return b >>> 30;
   endfunction

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
      localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
      logic [61:0]        sum;
      logic [61:0]        v_nx, r_nx;
      logic signed [63:0] h_nx;
      logic signed [31:0] xs;

      if (k == 0) begin : g_head
         assign vi[k]   = {1'b0, (31'h40000000 - opnd.x), 30'b0};
         assign ri[k]   = '0;
         assign hi[k]   = '0;
         assign xi[k]   = opnd.x;
         assign ni[k]   = opnd.neg;
         assign vldi[k] = opnd.valid;
      end else begin : g_link
         assign vi[k]   = v_ff[k-1];
         assign ri[k]   = r_ff[k-1];
         assign hi[k]   = h_ff[k-1];
         assign xi[k]   = x_ff[k-1];
         assign ni[k]   = neg_ff[k-1];
         assign vldi[k] = vld_ff[k-1];
      end

      assign xs  = $signed({1'b0, xi[k]});
      assign sum = ri[k] + BIT;
      assign v_nx = (vi[k] >= sum) ? vi[k] - sum : vi[k];
      assign r_nx = (vi[k] >= sum) ? (ri[k] >> 1) + BIT : ri[k] >> 1;

      if (k == 0) begin : g_h_first
         assign h_nx = ASIN_COEF[HORNER_STEPS] * xs;
      end else if (k < HORNER_STEPS) begin : g_h_step
         logic signed [63:0] tr;
         logic signed [31:0] p_k;
         assign tr   = trunc_q30(hi[k]);
         assign p_k  = tr[31:0] + ASIN_COEF[HORNER_STEPS-k];
         assign h_nx = p_k * xs;
      end else if (k == HORNER_STEPS) begin : g_h_last
         logic signed [63:0] tr;
         logic signed [31:0] p_k;
         assign tr   = trunc_q30(hi[k]);
         assign p_k  = tr[31:0] + ASIN_COEF[0];
         assign h_nx = 64'(p_k);
      end else begin : g_h_hold
         assign h_nx = hi[k];
      end

      always_ff @(posedge clock) begin
         v_ff[k]   <= v_nx;
         r_ff[k]   <= r_nx;
         h_ff[k]   <= h_nx;
         x_ff[k]   <= xi[k];
         neg_ff[k] <= ni[k];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vldi[k];
         end
      end
   end

   assign tprod_in = $signed({1'b0, r_ff[LAST][30:0]}) * $signed(h_ff[LAST][31:0]);

   assign t_full  = trunc_q30(tprod_ff);
   assign as_in   = $signed({2'b00, PIBY2_Q30}) - t_full[33:0];
   // floor at zero
   assign amag_in = as_in[33] ? 32'd0 : as_in[31:0];

   assign scaled_in = 46'(amag_ff) * 46'(CDEG_PER_RAD) + (46'd1 << 29);
   assign pitch_in  = aneg_ff ? $signed({1'b0, scaled_in[43:30]})
                              : -$signed({1'b0, scaled_in[43:30]});

   always_ff @(posedge clock) begin
      tprod_ff <= tprod_in;
      tneg_ff  <= neg_ff[LAST];
      amag_ff  <= amag_in;
      aneg_ff  <= tneg_ff;
      pitch_ff <= pitch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvld_ff    <= 1'b0;
         avld_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         tvld_ff    <= vld_ff[LAST];
         avld_ff    <= tvld_ff;
         out_vld_ff <= avld_ff;
      end
   end

   assign out_valid  = out_vld_ff;
   assign pitch_cdeg = pitch_ff;

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (pitch_ff <= 15'sd9010) && (pitch_ff >= -15'sd9010))
      else $error("pitch out of range");

endmodule

// File: hdl/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Converts an attitude quaternion into roll, pitch and yaw in centidegrees.
// ----------------------------------------------------------------------------
// Usage: the core accepts one quaternion word in every clock cycle; busy is
// always low, so a word is taken whenever start is high. Each word yields one
// result word, shown for a single cycle with rsp_valid high; the receiver cannot
// stall and must take it in that cycle. The latency is set by the pitch path:
// four front stages, then a square root that resolves one root bit per stage
// over 31 stages, then three stages of product, offset and scaling. Roll and
// yaw finish their 20-stage atan2 pipelines early and are held in a delay line
// until pitch catches up.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_w,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_z,
   output logic                          rsp_valid,
   output logic signed [15:0]            rsp_roll_cdeg,
   output logic signed [14:0]            rsp_pitch_cdeg,
   output logic signed [15:0]            rsp_yaw_cdeg
);
   import qte_pkg::*;

   localparam int LAT_FRONT = 4;
   localparam int LAT_ATAN  = 20;
   localparam int LAT_ASIN  = 34;
   localparam int ALIGN     = LAT_ASIN - LAT_ATAN;
   localparam int LAT_TOTAL = LAT_FRONT + LAT_ASIN;

   atan_opnd_type roll_opnd, yaw_opnd;
   asin_opnd_type asin_opnd;

   logic               roll_valid, yaw_valid, pitch_valid;
   logic signed [15:0] roll_cdeg, yaw_cdeg;
   logic signed [14:0] pitch_cdeg;

   logic signed [15:0] roll_dly_ff [ALIGN];
   logic signed [15:0] yaw_dly_ff  [ALIGN];
   logic               roll_vld_ff [ALIGN];
   logic               yaw_vld_ff  [ALIGN];

   assign busy = 1'b0;

   qte_front #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .roll_opnd (roll_opnd),
      .yaw_opnd  (yaw_opnd),
      .asin_opnd (asin_opnd)
   );

   qte_atan u_roll (
      .clock     (clock),
      .reset     (reset),
      .opnd      (roll_opnd),
      .out_valid (roll_valid),
      .cdeg      (roll_cdeg)
   );

   qte_atan u_yaw (
      .clock     (clock),
      .reset     (reset),
      .opnd      (yaw_opnd),
      .out_valid (yaw_valid),
      .cdeg      (yaw_cdeg)
   );

   qte_asin u_pitch (
      .clock      (clock),
      .reset      (reset),
      .opnd       (asin_opnd),
      .out_valid  (pitch_valid),
      .pitch_cdeg (pitch_cdeg)
   );

   // hold roll and yaw until pitch is ready
   always_ff @(posedge clock) begin
      roll_dly_ff[0] <= roll_cdeg;
      yaw_dly_ff[0]  <= yaw_cdeg;
      for (int i = 1; i < ALIGN; i++) begin
         roll_dly_ff[i] <= roll_dly_ff[i-1];
         yaw_dly_ff[i]  <= yaw_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALIGN; i++) begin
            roll_vld_ff[i] <= 1'b0;
            yaw_vld_ff[i]  <= 1'b0;
         end
      end else begin
         roll_vld_ff[0] <= roll_valid;
         yaw_vld_ff[0]  <= yaw_valid;
         for (int i = 1; i < ALIGN; i++) begin
            roll_vld_ff[i] <= roll_vld_ff[i-1];
            yaw_vld_ff[i]  <= yaw_vld_ff[i-1];
         end
      end
   end

   assign rsp_valid      = pitch_valid;
   assign rsp_roll_cdeg  = roll_dly_ff[ALIGN-1];
   assign rsp_pitch_cdeg = pitch_cdeg;
   assign rsp_yaw_cdeg   = yaw_dly_ff[ALIGN-1];

   a_paths_aligned: assert property (@(posedge clock) disable iff (reset)
      (pitch_valid == roll_vld_ff[ALIGN-1]) && (pitch_valid == yaw_vld_ff[ALIGN-1]))
      else $error("roll, pitch and yaw words out of step");

   a_word_delivered: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT_TOTAL rsp_valid)
      else $error("accepted word produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT_TOTAL))
      else $error("result without an accepted word");

endmodule
